// File: hdl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared definitions for the rational arithmetic reducer
// Widths, operation and status codes, and the work record that the front end
// hands to the reduction engine.
// ----------------------------------------------------------------------------
package rar_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int NMAG_W        = PROD_W + 1;
	localparam int RES_NUM_W     = 33;
	localparam int RES_DEN_W     = 31;
	localparam int EXT_W         = (NMAG_W > RES_NUM_W) ? NMAG_W : RES_NUM_W;
	localparam int DIV_CNT_W     = $clog2(NMAG_W);

	localparam int IN_DATA_W     = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
	localparam int IN_USER_W     = 2;
	localparam int OUT_DATA_W    = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
	localparam int OUT_USER_W    = 2;

	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_SUB,
		MODE_MUL,
		MODE_DIV
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ZERO_DEN,
		ST_DIV_ZERO
	} status_t;

	typedef struct packed {
		status_t             status;
		logic                neg;
		logic [NMAG_W-1:0]   nmag;
		logic [PROD_W-1:0]   dmag;
	} work_t;

endpackage

// File: hdl/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front: request intake and cross multiplication
// Checks each request for bad denominators, forms the unreduced numerator
// and denominator magnitudes with their sign, and pushes the work record.
// ----------------------------------------------------------------------------
module rar_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rar_pkg::IN_DATA_W-1:0] in_data,
	input  logic [rar_pkg::IN_USER_W-1:0] in_user,
	output logic                          wr_valid,
	input  logic                          wr_ready,
	output rar_pkg::work_t                wr_entry
);
	import rar_pkg::*;

	function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
		mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	logic                     adv;
	logic [OPERAND_WIDTH-1:0] na, da, nb, db;
	logic [OPERAND_WIDTH-1:0] na_m, da_m, nb_m, db_m;
	logic                     na_s, da_s, nb_s, db_s;
	mode_t                    mode_in;
	status_t                  status_in;

	logic                     v_s1, v_s2, v_s3;
	mode_t                    mode_s1, mode_s2;
	status_t                  status_s1, status_s2;
	logic [OPERAND_WIDTH-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1;
	logic                     sgn1_s1, sgn2_s1, sgn3_s1;
	logic [PROD_W-1:0]        p1_s2, p2_s2, p3_s2;
	logic                     sgn1_s2, sgn2_s2, sgn3_s2;
	work_t                    entry_s3;

	logic [NMAG_W-1:0]        a_ext, b_ext, sum, d_ab, d_ba;
	logic [NMAG_W-1:0]        nmag;
	logic                     nneg;

	assign na = in_data[OPERAND_WIDTH-1:0];
	assign da = in_data[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
	assign nb = in_data[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH];
	assign db = in_data[4*OPERAND_WIDTH-1:3*OPERAND_WIDTH];

	assign na_m = mag_of(na);
	assign da_m = mag_of(da);
	assign nb_m = mag_of(nb);
	assign db_m = mag_of(db);
	assign na_s = na[OPERAND_WIDTH-1];
	assign da_s = da[OPERAND_WIDTH-1];
	assign nb_s = nb[OPERAND_WIDTH-1];
	assign db_s = db[OPERAND_WIDTH-1];

	assign mode_in = mode_t'(in_user[1:0]);

	always_comb begin
		if (da == '0 || db == '0) begin
			status_in = ST_ZERO_DEN;
		end else if (mode_in == MODE_DIV && nb == '0) begin
			status_in = ST_DIV_ZERO;
		end else begin
			status_in = ST_OK;
		end
	end

	assign adv      = !v_s3 || wr_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign a_ext = NMAG_W'(p1_s2);
	assign b_ext = NMAG_W'(p2_s2);
	assign sum   = a_ext + b_ext;
	assign d_ab  = a_ext - b_ext;
	assign d_ba  = b_ext - a_ext;

	always_comb begin
		nmag = a_ext;
		nneg = sgn1_s2;
		case (mode_s2)
			MODE_ADD, MODE_SUB: begin
				if (sgn1_s2 == sgn2_s2) begin
					nmag = sum;
				end else if (p1_s2 >= p2_s2) begin
					nmag = d_ab;
				end else begin
					nmag = d_ba;
					nneg = sgn2_s2;
				end
			end
			default: begin
				nmag = a_ext;
				nneg = sgn1_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1   <= mode_in;
			status_s1 <= status_in;
			x1_s1     <= na_m;
			y1_s1     <= (mode_in == MODE_MUL) ? nb_m : db_m;
			x2_s1     <= nb_m;
			y2_s1     <= da_m;
			x3_s1     <= da_m;
			y3_s1     <= (mode_in == MODE_DIV) ? nb_m : db_m;
			sgn1_s1   <= na_s ^ ((mode_in == MODE_MUL) ? nb_s : db_s);
			sgn2_s1   <= nb_s ^ da_s ^ (mode_in == MODE_SUB);
			sgn3_s1   <= da_s ^ ((mode_in == MODE_DIV) ? nb_s : db_s);

			mode_s2   <= mode_s1;
			status_s2 <= status_s1;
			p1_s2     <= PROD_W'(x1_s1) * PROD_W'(y1_s1);
			p2_s2     <= PROD_W'(x2_s1) * PROD_W'(y2_s1);
			p3_s2     <= PROD_W'(x3_s1) * PROD_W'(y3_s1);
			sgn1_s2   <= sgn1_s1;
			sgn2_s2   <= sgn2_s1;
			sgn3_s2   <= sgn3_s1;

			entry_s3.status <= status_s2;
			entry_s3.neg    <= nneg ^ sgn3_s2;
			entry_s3.nmag   <= nmag;
			entry_s3.dmag   <= p3_s2;
		end
	end

	assign wr_valid = v_s3;
	assign wr_entry = entry_s3;

endmodule

// File: hdl/rar_queue.sv
// ----------------------------------------------------------------------------
// rar_queue: work queue between front end and reduction engine
// A small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module rar_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  rar_pkg::work_t wr_entry,
	output logic           rd_valid,
	input  logic           rd_ready,
	output rar_pkg::work_t rd_entry
);
	import rar_pkg::*;

	work_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign wr_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// File: hdl/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back: gcd reduction engine
// Strips common factors of two, runs a binary gcd on the rest, then divides
// numerator and denominator by the odd gcd one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rar_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_valid,
	output logic                           rd_ready,
	input  rar_pkg::work_t                 rd_entry,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rar_pkg::OUT_DATA_W-1:0] out_data,
	output logic [rar_pkg::OUT_USER_W-1:0] out_user
);
	import rar_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_TWOS,
		B_GCD,
		B_DIV,
		B_DONE
	} state_t;

	state_t                 state_q;
	logic [NMAG_W-1:0]      u_q, v_q, g_q, n_q, d_q, rn_q, rd_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   neg_q;
	status_t                status_q;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic [OUT_USER_W-1:0]  out_user_q;

	logic                   u_gt_v;
	logic [NMAG_W-1:0]      u_m_v, v_m_u;
	logic [NMAG_W:0]        rn_sh, rd_sh, g_ext, rn_sub, rd_sub;
	logic                   n_fit, d_fit;
	logic [EXT_W-1:0]       num_ext;
	logic [RES_NUM_W-1:0]   res_num;
	logic [RES_DEN_W-1:0]   res_den;

	assign u_gt_v = (u_q > v_q);
	assign u_m_v  = u_q - v_q;
	assign v_m_u  = v_q - u_q;

	assign g_ext  = {1'b0, g_q};
	assign rn_sh  = {rn_q, n_q[NMAG_W-1]};
	assign rd_sh  = {rd_q, d_q[NMAG_W-1]};
	assign rn_sub = rn_sh - g_ext;
	assign rd_sub = rd_sh - g_ext;
	assign n_fit  = (rn_sh >= g_ext);
	assign d_fit  = (rd_sh >= g_ext);

	assign num_ext = neg_q ? (EXT_W'(0) - EXT_W'(n_q)) : EXT_W'(n_q);
	assign res_num = num_ext[RES_NUM_W-1:0];
	assign res_den = RES_DEN_W'(d_q);

	assign rd_ready  = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != B_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (rd_valid) begin
						if (rd_entry.status != ST_OK || rd_entry.nmag == '0) begin
							state_q <= B_DONE;
						end else begin
							state_q <= B_TWOS;
						end
					end
				end
				B_TWOS: begin
					if (u_q[0] || v_q[0]) begin
						state_q <= B_GCD;
					end
				end
				B_GCD: begin
					if (u_q == v_q) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (cnt_q == DIV_CNT_W'(NMAG_W - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				status_q <= rd_entry.status;
				neg_q    <= 1'b0;
				u_q      <= rd_entry.nmag;
				v_q      <= NMAG_W'(rd_entry.dmag);
				n_q      <= '0;
				d_q      <= (rd_entry.status == ST_OK) ? NMAG_W'(1) : '0;
				if (rd_entry.status == ST_OK && rd_entry.nmag != '0) begin
					neg_q <= rd_entry.neg;
				end
			end
			B_TWOS: begin
				if (u_q[0] || v_q[0]) begin
					n_q <= u_q;
					d_q <= v_q;
				end else begin
					u_q <= {1'b0, u_q[NMAG_W-1:1]};
					v_q <= {1'b0, v_q[NMAG_W-1:1]};
				end
			end
			B_GCD: begin
				if (u_q == v_q) begin
					g_q   <= u_q;
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= '0;
				end else if (!u_q[0]) begin
					u_q <= {1'b0, u_q[NMAG_W-1:1]};
				end else if (!v_q[0]) begin
					v_q <= {1'b0, v_q[NMAG_W-1:1]};
				end else if (u_gt_v) begin
					u_q <= {1'b0, u_m_v[NMAG_W-1:1]};
				end else begin
					v_q <= {1'b0, v_m_u[NMAG_W-1:1]};
				end
			end
			B_DIV: begin
				rn_q  <= n_fit ? rn_sub[NMAG_W-1:0] : rn_sh[NMAG_W-1:0];
				rd_q  <= d_fit ? rd_sub[NMAG_W-1:0] : rd_sh[NMAG_W-1:0];
				n_q   <= {n_q[NMAG_W-2:0], n_fit};
				d_q   <= {d_q[NMAG_W-2:0], d_fit};
				cnt_q <= cnt_q + 1'b1;
			end
			B_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_data_q <= OUT_DATA_W'({res_den, res_num});
					out_user_q <= OUT_USER_W'(status_q);
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

// File: hdl/rational_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce: fraction add, subtract, multiply and divide
// Two signed fractions and an operation come in; the exact result leaves
// reduced to lowest terms with a positive denominator, or with an error
// status and a zero result.
//
//   Channel   Direction  tdata (low bit first)                tuser
//   s_axis    in         num_a, den_a, num_b, den_b           mode
//   m_axis    out        result_num[32:0], result_den[30:0]   status
//
// A request passes the registered stages s1, s2 and s3 of the multiply front
// end, then waits in a two-entry queue for the reduction engine. An error or
// a zero result goes from idle straight to done; otherwise the engine strips
// the common factors of two, runs the binary gcd steps and then the
// bit-serial divider over the 33-bit quotient width. It takes a new request
// only back in idle, once the previous result is in the output register.
// Reset clears all handshake state at once; there is no clearing pass.
// A stalled m_axis holds one result while the engine and queue keep working.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// num_a, den_a, num_b, den_b
	input  logic [rar_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [rar_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// result_num, result_den
	output logic [rar_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [rar_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import rar_pkg::*;

	logic  q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
	work_t q_wr_entry, q_rd_entry;

	rar_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_entry (q_wr_entry)
	);

	rar_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_entry (q_wr_entry),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_entry (q_rd_entry)
	);

	rar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (q_rd_valid),
		.rd_ready  (q_rd_ready),
		.rd_entry  (q_rd_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// File: hdl/rar_checker.sv
// ----------------------------------------------------------------------------
// rar_checker: port-level checks for the rational arithmetic reducer
// Watches the result channel for held results and consistent status codes.
// ----------------------------------------------------------------------------
module rar_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rar_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [rar_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import rar_pkg::*;

	logic [RES_NUM_W-1:0] num;
	logic [RES_DEN_W-1:0] den;
	logic                 ok;

	assign num = m_axis_tdata[RES_NUM_W-1:0];
	assign den = m_axis_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W];
	assign ok  = (m_axis_tuser == OUT_USER_W'(ST_OK));

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Result changed while stalled.");

	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ok |-> den != '0)
		else $error("Good result with a zero denominator.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !ok |-> m_axis_tdata == '0)
		else $error("Error result is not zero.");

	a_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ok && num == '0 |-> den == RES_DEN_W'(1))
		else $error("Zero result is not given as 0/1.");

endmodule

bind rational_arithmetic_reduce rar_checker u_rar_checker (.*);
